### design/nec_ir_pkg.sv
// nec_ir_pkg: interval windows, phase codes and event codes for the NEC IR interval decoder
// no dependencies; imported by nec_ir_interval_decoder
package nec_ir_pkg;

   localparam int unsigned IntervalWidth = 18;
   localparam int unsigned PhaseWidth    = 6;
   localparam int unsigned WordWidth     = 32;
   localparam int unsigned RepeatWidth   = 9;
   localparam int unsigned ErrorWidth    = 16;
   localparam int unsigned EventWidth    = 3;

   typedef logic [IntervalWidth-1:0]      interval_type;
   typedef logic [PhaseWidth-1:0]         phase_type;
   typedef logic [WordWidth-1:0]          word_type;
   typedef logic signed [RepeatWidth-1:0] repeats_type;
   typedef logic [ErrorWidth-1:0]         errors_type;
   typedef logic [EventWidth-1:0]         event_type;

   // windows, exclusive below and inclusive above
   localparam interval_type GapMax  = IntervalWidth'(108350);
   localparam interval_type HdrMax  = IntervalWidth'(14850);
   localparam interval_type HdrMin  = IntervalWidth'(12555);
   localparam interval_type RptMax  = IntervalWidth'(12305);
   localparam interval_type RptMin  = IntervalWidth'(10350);
   localparam interval_type OneMax  = IntervalWidth'(2464);
   localparam interval_type OneMin  = IntervalWidth'(2016);
   localparam interval_type ZeroMax = IntervalWidth'(1232);
   localparam interval_type ZeroMin = IntervalWidth'(1008);

   // phase codes: 0..31 receiving bit n
   localparam phase_type PhDone  = PhaseWidth'(32);
   localparam phase_type PhArmed = PhaseWidth'(33);
   localparam phase_type PhIdle  = PhaseWidth'(63);

   localparam repeats_type RepeatsInvalid = RepeatWidth'(-1);
   localparam repeats_type RepeatsMax     = RepeatWidth'(255);
   localparam repeats_type RepeatsFrame   = RepeatWidth'(1);
   localparam errors_type  ErrorsMax      = '1;

   localparam event_type EvStray  = EventWidth'(0);
   localparam event_type EvHeader = EventWidth'(1);
   localparam event_type EvBit    = EventWidth'(2);
   localparam event_type EvDone   = EventWidth'(3);
   localparam event_type EvRepeat = EventWidth'(4);
   localparam event_type EvError  = EventWidth'(5);
   localparam event_type EvArmed  = EventWidth'(6);

endpackage

### design/nec_ir_interval_decoder.sv
// nec_ir_interval_decoder: NEC IR frame decoder fed with falling-edge intervals
// depends on nec_ir_pkg
//
//  channel  dir  handshake        payload
//  req_     in   valid / stall    interval_us
//  rsp_     out  valid / stall    code_word, repeat_count, error_count, event_res
//
// One beat in, one beat out. The interval is registered on acceptance, then
// classified and folded into the decoder state once the output is free, which also
// loads the result register. A new interval is taken every cycle unless stalled.
// A stalled result holds the result register and the input register; req_stall rises
// only while both are full. Reset (synchronous) empties both registers and sets the
// decoder idle with the code cleared, repeat count invalid and error count zero.
module nec_ir_interval_decoder
   import nec_ir_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [IntervalWidth-1:0]      req_interval_us,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [WordWidth-1:0]          rsp_code_word,
   output logic signed [RepeatWidth-1:0] rsp_repeat_count,
   output logic [ErrorWidth-1:0]         rsp_error_count,
   output logic [EventWidth-1:0]         rsp_event_res
);

   logic         in_valid_ff;
   interval_type interval_ff;
   logic         out_valid_ff;
   word_type     out_word_ff;
   repeats_type  out_repeats_ff;
   errors_type   out_errors_ff;
   event_type    out_event_ff;

   phase_type    phase_ff, phase_in;
   word_type     shift_ff, shift_in;
   repeats_type  repeats_ff, repeats_in;
   errors_type   errors_ff, errors_in;
   event_type    event_in;

   logic out_free;
   logic work;
   logic take;
   logic is_gap, is_hdr, is_rpt, is_one, is_zero;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign work      = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign take      = req_valid && !req_stall;

   always_comb begin
      is_gap  = interval_ff > GapMax;
      is_hdr  = interval_ff > HdrMin && interval_ff <= HdrMax;
      is_rpt  = interval_ff > RptMin && interval_ff <= RptMax;
      is_one  = interval_ff > OneMin && interval_ff <= OneMax;
      is_zero = interval_ff > ZeroMin && interval_ff <= ZeroMax;
   end

   always_comb begin
      phase_in   = phase_ff;
      shift_in   = shift_ff;
      repeats_in = repeats_ff;
      errors_in  = errors_ff;
      event_in   = EvStray;
      if (is_gap) begin
         phase_in = PhIdle;
         event_in = EvStray;
      end else if (is_hdr) begin
         repeats_in = RepeatsInvalid;
         shift_in   = '0;
         phase_in   = '0;
         event_in   = EvHeader;
      end else if (is_rpt && phase_ff == PhArmed) begin
         phase_in = PhDone;
         if (repeats_ff < RepeatsMax) begin
            repeats_in = repeats_ff + RepeatWidth'(1);
         end
         event_in = EvRepeat;
      end else if ((is_one || is_zero) && phase_ff < PhDone) begin
         shift_in = {is_one, shift_ff[WordWidth-1:1]};
         phase_in = phase_ff + PhaseWidth'(1);
         if (phase_in == PhDone) begin
            repeats_in = RepeatsFrame;
            event_in   = EvDone;
         end else begin
            event_in = EvBit;
         end
      end else begin
         // failure or arming path, also taken by over-long header and repeat gaps
         if (phase_ff == PhDone) begin
            phase_in = PhArmed;
            event_in = EvArmed;
         end else if (phase_ff <= PhArmed) begin
            if (errors_ff != ErrorsMax) begin
               errors_in = errors_ff + ErrorWidth'(1);
            end
            phase_in = PhIdle;
            event_in = EvError;
         end else begin
            phase_in = PhIdle;
            event_in = EvStray;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         phase_ff     <= PhIdle;
         shift_ff     <= '0;
         repeats_ff   <= RepeatsInvalid;
         errors_ff    <= '0;
      end else begin
         if (take) begin
            in_valid_ff <= 1'b1;
         end else if (work) begin
            in_valid_ff <= 1'b0;
         end
         if (work) begin
            out_valid_ff <= 1'b1;
            phase_ff     <= phase_in;
            shift_ff     <= shift_in;
            repeats_ff   <= repeats_in;
            errors_ff    <= errors_in;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         interval_ff <= req_interval_us;
      end
      if (work) begin
         out_word_ff    <= shift_in;
         out_repeats_ff <= repeats_in;
         out_errors_ff  <= errors_in;
         out_event_ff   <= event_in;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_code_word    = out_word_ff;
   assign rsp_repeat_count = out_repeats_ff;
   assign rsp_error_count  = out_errors_ff;
   assign rsp_event_res    = out_event_ff;

endmodule
